@@ rtl/hcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants of the chunked body decoder
// Beat structures on both sides of the decoder core, result kind codes and
// the control characters that frame a chunked body.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // Kind of one result beat.
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // One input beat as it is held in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_body;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
    } result_t;

    // Status of the core, seen by the top level.
    typedef struct packed {
        logic busy;      // an input beat waits in the input register
        logic finished;  // done or error has been given
        logic push;      // a result goes into the output buffer this cycle
    } core_stat_t;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

endpackage

@@ rtl/hcbd_core.sv @@
// ----------------------------------------------------------------------------
// hcbd_core: input register and framing state of the chunked body decoder
// Holds one input beat, runs the size line / payload / trailer state update
// on it combinationally and hands any result to the output buffer.
// ----------------------------------------------------------------------------
module hcbd_core #(
    parameter int SIZE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  hcbd_pkg::in_item_t  in_item,
    input  logic                buf_ready,
    output logic                res_push,
    output hcbd_pkg::result_t   res,
    output hcbd_pkg::core_stat_t stat
);

    typedef enum logic [10:0] {
        PH_START   = 11'b000_0000_0001,
        PH_WS      = 11'b000_0000_0010,
        PH_WS_CR   = 11'b000_0000_0100,
        PH_DIG     = 11'b000_0000_1000,
        PH_TAIL    = 11'b000_0001_0000,
        PH_TAIL_CR = 11'b000_0010_0000,
        PH_DATA    = 11'b000_0100_0000,
        PH_CR1     = 11'b000_1000_0000,
        PH_CR2     = 11'b001_0000_0000,
        PH_DONE    = 11'b010_0000_0000,
        PH_ERR     = 11'b100_0000_0000
    } phase_t;

    hcbd_pkg::in_item_t   item_reg;
    logic                 item_vld_reg;
    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] accum_reg, accum_next;
    logic [SIZE_BITS-1:0] left_reg, left_next;
    logic                 seen_reg, seen_next;

    logic                 advance;
    logic [7:0]           b;
    logic                 hex_ok;
    logic [3:0]           hex_v;
    logic                 is_space;
    logic                 ovf;
    logic                 res_valid;
    hcbd_pkg::kind_t      res_kind;

    assign advance  = item_vld_reg && buf_ready;
    assign in_ready = !item_vld_reg || buf_ready;
    assign b        = item_reg.data_byte;

    always_comb begin
        hex_ok = 1'b1;
        hex_v  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            hex_v = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            hex_v = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            hex_v = 4'(b - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign is_space = (b == hcbd_pkg::CHAR_SPACE) || (b == hcbd_pkg::CHAR_TAB) ||
                      (b == hcbd_pkg::CHAR_LF) || (b == hcbd_pkg::CHAR_VT) ||
                      (b == hcbd_pkg::CHAR_FF) || (b == hcbd_pkg::CHAR_CR);

    // A further digit would push a set bit out of the top nibble.
    assign ovf = |accum_reg[SIZE_BITS-1:SIZE_BITS-4];

    always_comb begin
        logic do_ws;
        logic do_digit;
        logic do_lend;
        do_ws      = 1'b0;
        do_digit   = 1'b0;
        do_lend    = 1'b0;
        phase_next = phase_reg;
        accum_next = accum_reg;
        left_next  = left_reg;
        seen_next  = seen_reg;
        res_valid  = 1'b0;
        res_kind   = hcbd_pkg::KIND_DATA;

        if (item_reg.byte_present) begin
            unique case (phase_reg)
                PH_START, PH_WS: begin
                    do_ws = 1'b1;
                end
                PH_WS_CR: begin
                    if (b == hcbd_pkg::CHAR_LF) begin
                        do_lend = 1'b1;
                    end else begin
                        do_ws = 1'b1;
                    end
                end
                PH_DIG: begin
                    if (hex_ok) begin
                        do_digit = 1'b1;
                    end else if (b == hcbd_pkg::CHAR_CR) begin
                        phase_next = PH_TAIL_CR;
                    end else begin
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    if (b == hcbd_pkg::CHAR_CR) begin
                        phase_next = PH_TAIL_CR;
                    end
                end
                PH_TAIL_CR: begin
                    if (b == hcbd_pkg::CHAR_LF) begin
                        do_lend = 1'b1;
                    end else if (b != hcbd_pkg::CHAR_CR) begin
                        phase_next = PH_TAIL;
                    end
                end
                PH_DATA: begin
                    left_next = left_reg - SIZE_BITS'(1);
                    if (left_reg == SIZE_BITS'(1)) begin
                        phase_next = PH_CR1;
                    end
                    res_valid = 1'b1;
                    res_kind  = hcbd_pkg::KIND_DATA;
                end
                PH_CR1: begin
                    if (b == hcbd_pkg::CHAR_CR) begin
                        phase_next = PH_CR2;
                    end else begin
                        phase_next = PH_ERR;
                        res_valid  = 1'b1;
                        res_kind   = hcbd_pkg::KIND_ERR;
                    end
                end
                PH_CR2: begin
                    if (b == hcbd_pkg::CHAR_LF) begin
                        accum_next = '0;
                        seen_next  = 1'b0;
                        phase_next = PH_WS;
                    end else begin
                        phase_next = PH_ERR;
                        res_valid  = 1'b1;
                        res_kind   = hcbd_pkg::KIND_ERR;
                    end
                end
                default: begin
                    // Done and error swallow every beat.
                end
            endcase
        end

        // Whitespace before the digits of a size line.
        if (do_ws) begin
            if (hex_ok) begin
                do_digit = 1'b1;
            end else if (b == hcbd_pkg::CHAR_CR) begin
                phase_next = PH_WS_CR;
            end else if (is_space) begin
                phase_next = PH_WS;
            end else begin
                phase_next = PH_TAIL;
            end
        end

        if (do_digit) begin
            if (ovf) begin
                phase_next = PH_ERR;
                res_valid  = 1'b1;
                res_kind   = hcbd_pkg::KIND_ERR;
            end else begin
                accum_next = {accum_reg[SIZE_BITS-5:0], hex_v};
                seen_next  = 1'b1;
                phase_next = PH_DIG;
            end
        end

        // CR LF at the end of a size line.
        if (do_lend) begin
            if (!seen_reg) begin
                phase_next = PH_ERR;
                res_valid  = 1'b1;
                res_kind   = hcbd_pkg::KIND_ERR;
            end else if (accum_reg == '0) begin
                phase_next = PH_DONE;
                res_valid  = 1'b1;
                res_kind   = hcbd_pkg::KIND_DONE;
            end else begin
                left_next  = accum_reg;
                phase_next = PH_DATA;
            end
        end

        // End of body: done only if nothing came at all, otherwise an
        // error that replaces any payload byte of the same beat.
        if (item_reg.end_of_body && phase_next != PH_DONE && phase_next != PH_ERR) begin
            res_valid = 1'b1;
            if (phase_next == PH_START) begin
                phase_next = PH_DONE;
                res_kind   = hcbd_pkg::KIND_DONE;
            end else begin
                phase_next = PH_ERR;
                res_kind   = hcbd_pkg::KIND_ERR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
            phase_reg    <= PH_START;
            accum_reg    <= '0;
            left_reg     <= '0;
            seen_reg     <= 1'b0;
        end else begin
            if (in_ready) begin
                item_vld_reg <= in_valid;
            end
            if (advance) begin
                phase_reg <= phase_next;
                accum_reg <= accum_next;
                left_reg  <= left_next;
                seen_reg  <= seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign res_push     = advance && res_valid;
    assign res.kind     = res_kind;
    assign res.out_byte = (res_kind == hcbd_pkg::KIND_DATA) ? b : 8'd0;

    assign stat.busy     = item_vld_reg;
    assign stat.finished = (phase_reg == PH_DONE) || (phase_reg == PH_ERR);
    assign stat.push     = res_push;

endmodule

@@ rtl/hcbd_out_buf.sv @@
// ----------------------------------------------------------------------------
// hcbd_out_buf: two-entry result buffer
// Registers result beats and keeps its ready free of the downstream ready,
// so the two sides of the decoder are parted by registers.
// ----------------------------------------------------------------------------
module hcbd_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  hcbd_pkg::result_t push_data,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output hcbd_pkg::result_t out_data
);

    localparam int DEPTH = 2;

    hcbd_pkg::result_t mem_reg [DEPTH];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign ready     = (count_reg != 2'(DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/http_chunked_body_decoder.sv @@
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked transfer decoding
// Takes the raw chunked body one byte per beat and gives the payload bytes,
// then one done or error status beat.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries one body byte per beat in s_axis_tdata. The
// flag in s_axis_tuser says whether that byte is present, so a final empty
// beat can close the body, and s_axis_tlast marks the last beat of the body.
// The master channel gives one beat per payload byte (kind data) and then
// exactly one status beat, done or framing error; status beats carry zero
// data. A consumer should hold the payload and drop it when error arrives.
// Beats that carry only size lines or CR LF trailers produce no output.
// Throughput is one beat per cycle on both sides; the per-beat work is one
// state update, a shift of the size accumulator or a decrement of the
// byte count, between the input register and the result buffer.
// An accepted input beat is held in the input register, and its result is
// registered in the result buffer. A stall on the master side fills that
// two-entry buffer, after which s_axis_tready drops; no beat is lost or
// repeated. After the status beat every further input beat is accepted and
// ignored until reset. Reset (aresetn low, synchronous) empties the buffers
// and returns the decoder to the start of the first size line.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0] s_axis_tuser,   // [0] byte_present
    input  logic       s_axis_tlast,   // end_of_body
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser    // [1:0] kind
);

    hcbd_pkg::in_item_t   in_item;
    hcbd_pkg::result_t    res;
    hcbd_pkg::result_t    out_res;
    hcbd_pkg::core_stat_t stat;
    logic                 buf_ready;
    logic                 res_push;

    assign in_item.data_byte    = s_axis_tdata;
    assign in_item.byte_present = s_axis_tuser[0];
    assign in_item.end_of_body  = s_axis_tlast;

    // Framing state and the input register.
    hcbd_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .buf_ready (buf_ready),
        .res_push  (res_push),
        .res       (res),
        .stat      (stat)
    );

    // Result buffer in front of the master channel.
    hcbd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .ready     (buf_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = out_res.out_byte;
    assign m_axis_tuser = out_res.kind;

    // A result is only pushed when the buffer has room.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.push |-> buf_ready)
        else $error("result pushed into a full buffer");

    // Once the status has been given, no further result is produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat.finished |-> !stat.push)
        else $error("result produced after the status beat");

    // The input side only stalls while a beat waits in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> stat.busy)
        else $error("input stalled with an empty input register");

    // Status beats carry zero data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != hcbd_pkg::KIND_DATA) |-> (m_axis_tdata == 8'd0))
        else $error("status beat with nonzero data");

endmodule

@@ dv/tb_http_chunked_body_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder: self-checking bench for the chunked decoder
// Sends one chunked body per run (well-formed chunks with random payload,
// whitespace, leading zeros and line extensions) and closes it with a done
// or framing-error ending picked at random. A decoder model in the bench
// predicts every payload and status beat, and each master-side beat is
// checked against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;

    localparam int SIZE_W = 32;

    // Decoder phases as the bench model tracks them.
    typedef enum int {
        DP_START, DP_WS, DP_WS_CR, DP_DIG, DP_TAIL, DP_TAIL_CR,
        DP_DATA, DP_CR1, DP_CR2, DP_DONE, DP_ERR
    } dec_phase_t;

    // Ways the body may close; one is drawn per run.
    typedef enum int {
        CLOSE_DONE, CLOSE_NO_DIGITS, CLOSE_TOO_WIDE, CLOSE_BAD_TRAILER, CLOSE_EARLY
    } body_close_t;

    // One body beat waiting to be sent. When hold is set, the sender waits
    // until every predicted result has come back before offering it.
    typedef struct {
        hcbd_pkg::in_item_t beat;
        bit                 hold;
    } body_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic [0:0] s_axis_tuser = 1'b0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;

    body_beat_t         body_q[$];      // beats still to be offered
    hcbd_pkg::result_t  decoded_q[$];   // predicted payload and status beats

    // Model state, set to the reset values once; reset is never repeated.
    dec_phase_t           dec_ph = DP_START;
    logic [SIZE_W-1:0]    size_acc = '0;
    logic [SIZE_W-1:0]    bytes_left = '0;
    bit                   digit_seen = 1'b0;

    // Handshake flags set at the rising edge, read by the falling-edge drivers.
    bit          in_fire = 1'b0;
    bit          out_fire = 1'b0;
    int unsigned n_beats_in = 0;
    int unsigned n_results = 0;
    int unsigned n_errors = 0;
    int unsigned n_built = 0;
    bit          pause_next = 1'b0;

    hcbd_pkg::result_t want_r;

    http_chunked_body_decoder #(
        .SIZE_BITS(SIZE_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
        .s_axis_tuser  (s_axis_tuser),   // [0] byte_present
        .s_axis_tlast  (s_axis_tlast),   // end_of_body
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte
        .m_axis_tuser  (m_axis_tuser)    // [1:0] kind
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Reset is held low at the start and released on a falling edge.
    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Hard limit: a run that has not ended by then stops with errors reported.
    initial begin
        #5_000_000;
        $display("tb_http_chunked_body_decoder: errors");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 40) begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    // Bench model of the decoder: advances the phase for one accepted beat
    // and queues the result beat it causes, if any.
    task automatic decode_beat(input logic [7:0] b, input logic present, input logic last);
        hcbd_pkg::kind_t   k;
        hcbd_pkg::result_t r;
        bit                has;
        bit                is_hex;
        bit                add_nib;
        bit                line_end;
        logic [3:0]        nib;
        has      = 1'b0;
        k        = hcbd_pkg::KIND_DATA;
        is_hex   = 1'b1;
        add_nib  = 1'b0;
        line_end = 1'b0;
        nib      = 4'd0;
        // Once done or error has been given, nothing is looked at until reset.
        if (dec_ph == DP_DONE || dec_ph == DP_ERR) begin
            return;
        end
        if (present) begin
            if (b >= "0" && b <= "9") begin
                nib = 4'(b - "0");
            end else if (b >= "a" && b <= "f") begin
                nib = 4'(b - "a" + 8'd10);
            end else if (b >= "A" && b <= "F") begin
                nib = 4'(b - "A" + 8'd10);
            end else begin
                is_hex = 1'b0;
            end
            // A CR in the leading whitespace that is not followed by LF is
            // just more whitespace; the byte after it is taken afresh.
            if (dec_ph == DP_WS_CR && b != hcbd_pkg::CHAR_LF) begin
                dec_ph = DP_WS;
            end
            case (dec_ph)
                DP_START, DP_WS: begin
                    if (is_hex) begin
                        add_nib = 1'b1;
                    end else if (b == hcbd_pkg::CHAR_CR) begin
                        dec_ph = DP_WS_CR;
                    end else if (b == hcbd_pkg::CHAR_SPACE || b == hcbd_pkg::CHAR_TAB ||
                                 b == hcbd_pkg::CHAR_LF || b == hcbd_pkg::CHAR_VT ||
                                 b == hcbd_pkg::CHAR_FF) begin
                        dec_ph = DP_WS;
                    end else begin
                        dec_ph = DP_TAIL;
                    end
                end
                DP_WS_CR: begin
                    line_end = 1'b1;
                end
                DP_DIG: begin
                    if (is_hex) begin
                        add_nib = 1'b1;
                    end else begin
                        dec_ph = (b == hcbd_pkg::CHAR_CR) ? DP_TAIL_CR : DP_TAIL;
                    end
                end
                DP_TAIL: begin
                    if (b == hcbd_pkg::CHAR_CR) begin
                        dec_ph = DP_TAIL_CR;
                    end
                end
                DP_TAIL_CR: begin
                    if (b == hcbd_pkg::CHAR_LF) begin
                        line_end = 1'b1;
                    end else if (b != hcbd_pkg::CHAR_CR) begin
                        dec_ph = DP_TAIL;
                    end
                end
                DP_DATA: begin
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == '0) begin
                        dec_ph = DP_CR1;
                    end
                    has = 1'b1;
                end
                DP_CR1: begin
                    if (b == hcbd_pkg::CHAR_CR) begin
                        dec_ph = DP_CR2;
                    end else begin
                        dec_ph = DP_ERR;
                        has    = 1'b1;
                        k      = hcbd_pkg::KIND_ERR;
                    end
                end
                DP_CR2: begin
                    if (b == hcbd_pkg::CHAR_LF) begin
                        size_acc   = '0;
                        digit_seen = 1'b0;
                        dec_ph     = DP_WS;
                    end else begin
                        dec_ph = DP_ERR;
                        has    = 1'b1;
                        k      = hcbd_pkg::KIND_ERR;
                    end
                end
                default: begin
                end
            endcase
            // A digit that would shift a set bit out of the size is an error
            // at once; leading zeros never get here with a set top nibble.
            if (add_nib) begin
                if (size_acc[SIZE_W-1 -: 4] != 4'd0) begin
                    dec_ph = DP_ERR;
                    has    = 1'b1;
                    k      = hcbd_pkg::KIND_ERR;
                end else begin
                    size_acc   = {size_acc[SIZE_W-5:0], nib};
                    digit_seen = 1'b1;
                    dec_ph     = DP_DIG;
                end
            end
            if (line_end) begin
                if (!digit_seen) begin
                    dec_ph = DP_ERR;
                    has    = 1'b1;
                    k      = hcbd_pkg::KIND_ERR;
                end else if (size_acc == '0) begin
                    dec_ph = DP_DONE;
                    has    = 1'b1;
                    k      = hcbd_pkg::KIND_DONE;
                end else begin
                    bytes_left = size_acc;
                    dec_ph     = DP_DATA;
                end
            end
        end
        // End of body: done only if nothing at all was received, otherwise
        // an error that replaces any payload byte of the same beat.
        if (last && dec_ph != DP_DONE && dec_ph != DP_ERR) begin
            has = 1'b1;
            if (dec_ph == DP_START) begin
                dec_ph = DP_DONE;
                k      = hcbd_pkg::KIND_DONE;
            end else begin
                dec_ph = DP_ERR;
                k      = hcbd_pkg::KIND_ERR;
            end
        end
        if (has) begin
            r.out_byte = (k == hcbd_pkg::KIND_DATA) ? b : 8'h00;
            r.kind     = k;
            decoded_q.insert(decoded_q.size(), r);
        end
    endtask

    // ------------------------------------------------------------------
    // Body builders
    // ------------------------------------------------------------------

    task automatic add_beat(input logic [7:0] d, input logic present, input logic last);
        body_beat_t bb;
        bb.beat.data_byte    = d;
        bb.beat.byte_present = present;
        bb.beat.end_of_body  = last;
        bb.hold              = pause_next;
        pause_next           = 1'b0;
        body_q.insert(body_q.size(), bb);
        n_built++;
    endtask

    // Now and then an empty beat goes in front of a real byte.
    task automatic put_byte(input logic [7:0] d);
        if ($urandom_range(0, 24) == 0) begin
            add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        add_beat(d, 1'b1, 1'b0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) begin
            return 8'h30 + nib;
        end
        return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(0, 5))
            0: return hcbd_pkg::CHAR_SPACE;
            1: return hcbd_pkg::CHAR_TAB;
            2: return hcbd_pkg::CHAR_LF;
            3: return hcbd_pkg::CHAR_VT;
            4: return hcbd_pkg::CHAR_CR;
            default: return hcbd_pkg::CHAR_FF;
        endcase
    endfunction

    // Size line: optional whitespace, optional leading zeros, the size in
    // hex, an optional extension with stray CRs, then CR LF.
    task automatic put_size_line(input int unsigned size);
        int         n_ws;
        int         n_zero;
        int         n_nib;
        bit         upper;
        logic [7:0] c;
        logic [7:0] prev;
        n_ws   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        n_zero = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        upper  = 1'($urandom_range(0, 1));
        prev   = 8'h00;
        // CR LF inside the whitespace would end a line without digits.
        repeat (n_ws) begin
            c = ws_char();
            if (prev == hcbd_pkg::CHAR_CR && c == hcbd_pkg::CHAR_LF) begin
                c = hcbd_pkg::CHAR_SPACE;
            end
            put_byte(c);
            prev = c;
        end
        repeat (n_zero) put_byte("0");
        n_nib = 1;
        while (n_nib < 8 && (size >> (4 * n_nib)) != 0) n_nib++;
        for (int i = n_nib - 1; i >= 0; i--) begin
            put_byte(hex_char(4'(size >> (4 * i)), upper));
        end
        if ($urandom_range(0, 3) == 0) begin
            put_byte($urandom_range(0, 1) ? ";" : hcbd_pkg::CHAR_SPACE);
            repeat ($urandom_range(0, 6)) begin
                c = 8'($urandom_range(0, 255));
                if (c == hcbd_pkg::CHAR_CR) begin
                    // A lone CR, then a byte that keeps the line open.
                    put_byte(hcbd_pkg::CHAR_CR);
                    c = 8'($urandom_range(0, 255));
                    if (c == hcbd_pkg::CHAR_CR || c == hcbd_pkg::CHAR_LF) begin
                        c = "x";
                    end
                end
                put_byte(c);
            end
        end
        put_byte(hcbd_pkg::CHAR_CR);
        put_byte(hcbd_pkg::CHAR_LF);
    endtask

    task automatic put_chunk(input int unsigned len, input bit with_trailer);
        put_size_line(len);
        repeat (len) put_byte(8'($urandom_range(0, 255)));
        if (with_trailer) begin
            put_byte(hcbd_pkg::CHAR_CR);
            put_byte(hcbd_pkg::CHAR_LF);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial begin
        // Directed opening: all whitespace kinds, a lone CR before and
        // after the digits, a leading zero, an extension with a CR CR LF
        // ending, and payload bytes at the extremes and one equal to CR.
        logic [7:0]  opening [23];
        body_close_t close_kind;
        int unsigned next_pause;
        int unsigned len;
        int unsigned k;
        logic [7:0]  c;

        opening = '{
            hcbd_pkg::CHAR_SPACE, hcbd_pkg::CHAR_CR, "0", "1", hcbd_pkg::CHAR_CR, ";",
            hcbd_pkg::CHAR_CR, hcbd_pkg::CHAR_CR, hcbd_pkg::CHAR_LF,
            8'h00, hcbd_pkg::CHAR_CR, hcbd_pkg::CHAR_LF,
            hcbd_pkg::CHAR_TAB, hcbd_pkg::CHAR_LF, hcbd_pkg::CHAR_VT, hcbd_pkg::CHAR_FF,
            "2", hcbd_pkg::CHAR_CR, hcbd_pkg::CHAR_LF,
            8'hFF, hcbd_pkg::CHAR_CR, hcbd_pkg::CHAR_CR, hcbd_pkg::CHAR_LF};

        add_beat(8'h55, 1'b0, 1'b0);
        foreach (opening[i]) add_beat(opening[i], 1'b1, 1'b0);

        // Random chunks; the sender drains the decoder every 500 beats.
        next_pause = 0;
        while (n_built < 1900) begin
            if (n_built >= next_pause) begin
                pause_next = 1'b1;
                next_pause += 500;
            end
            k = $urandom_range(0, 99);
            if (k == 0) begin
                len = $urandom_range(200, 300);
            end else if (k < 10) begin
                len = $urandom_range(17, 64);
            end else begin
                len = $urandom_range(1, 16);
            end
            put_chunk(len, 1'b1);
        end

        close_kind = body_close_t'($urandom_range(0, 4));
        case (close_kind)
            CLOSE_DONE: begin
                put_size_line(0);
            end
            CLOSE_NO_DIGITS: begin
                repeat ($urandom_range(0, 3)) put_byte(ws_char());
                if ($urandom_range(0, 1)) begin
                    put_byte(";");
                end
                put_byte(hcbd_pkg::CHAR_CR);
                put_byte(hcbd_pkg::CHAR_LF);
            end
            CLOSE_TOO_WIDE: begin
                // Nine significant digits after optional leading zeros.
                repeat ($urandom_range(0, 4)) put_byte("0");
                put_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
                repeat (8) begin
                    put_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                end
            end
            CLOSE_BAD_TRAILER: begin
                put_chunk($urandom_range(1, 8), 1'b0);
                c = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1)) begin
                    if (c == hcbd_pkg::CHAR_CR) begin
                        c = hcbd_pkg::CHAR_LF;
                    end
                    put_byte(c);
                end else begin
                    if (c == hcbd_pkg::CHAR_LF) begin
                        c = hcbd_pkg::CHAR_CR;
                    end
                    put_byte(hcbd_pkg::CHAR_CR);
                    put_byte(c);
                end
            end
            default: begin
                // Body ends early: inside a size line, or inside a payload
                // with or without a byte in the final beat.
                if ($urandom_range(0, 2) == 0) begin
                    put_byte("1");
                    add_beat("2", 1'b1, 1'b1);
                end else begin
                    len = $urandom_range(2, 12);
                    put_size_line(len);
                    repeat ($urandom_range(0, len - 1)) put_byte(8'($urandom_range(0, 255)));
                    add_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                end
            end
        endcase

        // Beats after the status are taken and ignored.
        for (int i = 0; i < 12; i++) begin
            add_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     (i == 3) ? 1'b1 : 1'(($urandom_range(0, 3) == 0)));
        end

        while (!aresetn) @(posedge aclk);
        while (body_q.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (decoded_q.size() != 0) @(posedge aclk);
        // Wait out the input register and the result buffer; anything that shows
        // up now is an unexpected beat and is caught by the checker.
        repeat (8) @(posedge aclk);
        if (decoded_q.size() != 0) begin
            flag_mismatch($sformatf("%0d predicted beats never arrived", decoded_q.size()));
        end
        if (n_errors == 0) begin
            $display("tb_http_chunked_body_decoder: clean");
        end else begin
            $display("tb_http_chunked_body_decoder: errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: drives the slave channel on the falling edge. A beat stays on
    // offer until it is taken; after each taken beat a random gap is drawn,
    // except in burst stretches where there is no gap.
    // ------------------------------------------------------------------
    int unsigned send_gap = 0;
    int unsigned n_offered = 0;
    bit          send_burst = 1'b0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && !in_fire) begin
                // Beat still waiting for s_axis_tready.
            end else if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap--;
            end else if (body_q.size() != 0 &&
                         !(body_q[0].hold && decoded_q.size() != 0)) begin
                s_axis_tdata  <= body_q[0].beat.data_byte;
                s_axis_tuser  <= body_q[0].beat.byte_present;
                s_axis_tlast  <= body_q[0].beat.end_of_body;
                s_axis_tvalid <= 1'b1;
                body_q.pop_front();
                n_offered++;
                if (n_offered % 64 == 0) begin
                    send_burst = ($urandom_range(0, 2) == 0);
                end
                send_gap = send_burst ? 0 : $urandom_range(0, 6);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: drives m_axis_tready on the falling edge. After each taken
    // beat it may wait before it is ready again. Once, with a result pending
    // after some 300 input beats, it holds m_axis_tready low so the result
    // buffer fills and the decoder has to stall its input.
    // ------------------------------------------------------------------
    int unsigned take_wait = 0;
    int unsigned long_hold = 0;
    bit          long_hold_done = 1'b0;
    bit          take_burst = 1'b0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_fire) begin
                if (n_results % 64 == 0) begin
                    take_burst = ($urandom_range(0, 2) == 0);
                end
                take_wait = take_burst ? 0 : $urandom_range(0, 6);
            end
            if (!long_hold_done && n_beats_in >= 300 && m_axis_tvalid) begin
                long_hold      = 400;
                long_hold_done = 1'b1;
            end
            if (long_hold != 0) begin
                m_axis_tready <= 1'b0;
                long_hold--;
            end else if (take_wait != 0) begin
                m_axis_tready <= 1'b0;
                take_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, a taken input beat is run through the
    // model and a taken result beat is checked field by field against the
    // oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        in_fire  = 1'b0;
        out_fire = 1'b0;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_fire = 1'b1;
                n_beats_in++;
                decode_beat(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                out_fire = 1'b1;
                n_results++;
                if (decoded_q.size() == 0) begin
                    flag_mismatch($sformatf("result %0d: kind %0d data %h with none predicted",
                                            n_results, m_axis_tuser, m_axis_tdata));
                end else begin
                    want_r = decoded_q.pop_front();
                    if (m_axis_tuser !== want_r.kind) begin
                        flag_mismatch($sformatf("result %0d: kind %0d, predicted %s",
                                                n_results, m_axis_tuser, want_r.kind.name()));
                    end
                    if (m_axis_tdata !== want_r.out_byte) begin
                        flag_mismatch($sformatf("result %0d: out_byte %h, predicted %h",
                                                n_results, m_axis_tdata, want_r.out_byte));
                    end
                end
            end
        end
    end

endmodule
